/* design/blmp_pkg.sv */
package blmp_pkg;

	localparam int WORD_BITS  = 64;
	localparam int FIELD_BITS = 64;
	localparam int CNT_BITS   = $clog2(WORD_BITS);
	localparam int NUM_LANES  = 7;
	localparam int SUM_BITS   = WORD_BITS + 2;

	// Lane numbering: four products of accumulator by base, three of base by itself.
	localparam int LANE_ATT = 0;
	localparam int LANE_ATC = 1;
	localparam int LANE_ACT = 2;
	localparam int LANE_ACC = 3;
	localparam int LANE_BTT = 4;
	localparam int LANE_BTC = 5;
	localparam int LANE_BCC = 6;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

	// Both operands are already below m.
	function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
		logic [WORD_BITS:0] s;
		logic [WORD_BITS:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - {1'b0, m};
		if (s >= {1'b0, m}) begin
			return d[WORD_BITS-1:0];
		end
		return s[WORD_BITS-1:0];
	endfunction

	// Both operands are already below m.
	function automatic word_t sub_mod(input word_t a, input word_t b, input word_t m);
		word_t d;
		d = a - b;
		if (a < b) begin
			return d + m;
		end
		return d;
	endfunction

endpackage

/* design/blmp_mod_mul.sv */
module blmp_mod_mul import blmp_pkg::*; (
	input  logic      clk,
	input  lane_ctl_t ctl,
	input  word_t     a,
	input  word_t     b,
	input  word_t     m,
	output word_t     prod
);

	word_t r_q;
	word_t b_q;

	logic [SUM_BITS-1:0] s;
	logic [SUM_BITS-1:0] m1;
	logic [SUM_BITS-1:0] m2;
	logic [SUM_BITS-1:0] d1;
	logic [SUM_BITS-1:0] d2;
	word_t               r_nx;

	// One bit of b per cycle while ctl.step is high, most significant first: r = 2r + bit*a, reduced below m.
	always_comb begin
		s  = SUM_BITS'({r_q, 1'b0}) + (b_q[WORD_BITS-1] ? SUM_BITS'(a) : '0);
		m1 = SUM_BITS'(m);
		m2 = SUM_BITS'({m, 1'b0});
		d1 = s - m1;
		d2 = s - m2;
		priority if (s >= m2) begin
			r_nx = d2[WORD_BITS-1:0];
		end else if (s >= m1) begin
			r_nx = d1[WORD_BITS-1:0];
		end else begin
			r_nx = s[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_q <= '0;
			b_q <= b;
		end else if (ctl.step) begin
			r_q <= r_nx;
			b_q <= {b_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign prod = r_q;

endmodule

/* design/blmp_core.sv */
module blmp_core import blmp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t n_in,
	input  word_t m_in,
	output logic  ready,
	output logic  done,
	input  logic  take,
	output word_t result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_C1   = 3'd3;
	localparam logic [2:0] ST_C2   = 3'd4;
	localparam logic [2:0] ST_C3   = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]          state_q;
	logic [CNT_BITS-1:0] cnt_q;
	word_t               n_q;
	word_t               m_q;
	word_t               at_q;
	word_t               ac_q;
	word_t               bt_q;
	word_t               bc_q;
	word_t               ea_q;
	word_t               fa_q;
	word_t               eb_q;
	word_t               fb_q;
	word_t               res_q;

	lane_ctl_t ctl;
	word_t     a_op [NUM_LANES];
	word_t     b_op [NUM_LANES];
	word_t     p    [NUM_LANES];
	word_t     at_nx;
	word_t     n_nx;

	assign ctl = '{load: (state_q == ST_LOAD), step: (state_q == ST_MUL)};

	always_comb begin
		a_op[LANE_ATT] = at_q; b_op[LANE_ATT] = bt_q;
		a_op[LANE_ATC] = at_q; b_op[LANE_ATC] = bc_q;
		a_op[LANE_ACT] = ac_q; b_op[LANE_ACT] = bt_q;
		a_op[LANE_ACC] = ac_q; b_op[LANE_ACC] = bc_q;
		a_op[LANE_BTT] = bt_q; b_op[LANE_BTT] = bt_q;
		a_op[LANE_BTC] = bt_q; b_op[LANE_BTC] = bc_q;
		a_op[LANE_BCC] = bc_q; b_op[LANE_BCC] = bc_q;
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		blmp_mod_mul u_mul (
			.clk  (clk),
			.ctl  (ctl),
			.a    (a_op[g]),
			.b    (b_op[g]),
			.m    (m_q),
			.prod (p[g])
		);
	end

	assign at_nx = n_q[0] ? add_mod(fa_q, ea_q, m_q) : at_q;
	assign n_nx  = n_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (m_in[WORD_BITS-1:1] == '0 || n_in == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: state_q <= ST_MUL;
				ST_MUL: begin
					if (cnt_q == CNT_BITS'(WORD_BITS - 1)) begin
						state_q <= ST_C1;
					end
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: begin
					if (n_nx == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The sixfold product is built by doubling: 2tt, then 4tt, each added into the T sum.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q   <= n_in;
				m_q   <= m_in;
				at_q  <= '0;
				ac_q  <= word_t'(1);
				bt_q  <= word_t'(1);
				bc_q  <= '0;
				res_q <= '0;
			end
			ST_LOAD: cnt_q <= '0;
			ST_MUL:  cnt_q <= cnt_q + CNT_BITS'(1);
			ST_C1: begin
				ea_q <= add_mod(p[LANE_ATT], p[LANE_ATT], m_q);
				fa_q <= add_mod(p[LANE_ATC], p[LANE_ACT], m_q);
				eb_q <= add_mod(p[LANE_BTT], p[LANE_BTT], m_q);
				fb_q <= add_mod(p[LANE_BTC], p[LANE_BTC], m_q);
				if (n_q[0]) begin
					ac_q <= sub_mod(p[LANE_ACC], p[LANE_ATT], m_q);
				end
				bc_q <= sub_mod(p[LANE_BCC], p[LANE_BTT], m_q);
			end
			ST_C2: begin
				fa_q <= add_mod(fa_q, ea_q, m_q);
				ea_q <= add_mod(ea_q, ea_q, m_q);
				fb_q <= add_mod(fb_q, eb_q, m_q);
				eb_q <= add_mod(eb_q, eb_q, m_q);
			end
			ST_C3: begin
				at_q  <= at_nx;
				bt_q  <= add_mod(fb_q, eb_q, m_q);
				n_q   <= n_nx;
				res_q <= at_nx;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign ready  = (state_q == ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign result = res_q;

endmodule

/* design/balancing_lucas_mod_power_top.sv */
// Channel  Direction  tdata                              tuser
// s_axis   in         [63:0] index_n, [127:64] modulus   none
// m_axis   out        [63:0] term_mod                    [0] is_zero
//
// A request with a modulus of one or less, or with index zero, goes straight to the done state.
// Otherwise each bit of the index up to its highest set bit passes through the load, multiply and
// three combine states, with seven bit-serial modular multipliers working side by side.
// The asynchronous reset clears the sequencer and the output register valid flag.
// A finished result waits in the output register while the next request is taken and worked on.
module balancing_lucas_mod_power_top import blmp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // index_n [63:0], modulus [127:64]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,   // term_mod [63:0]
	output logic [0:0]   m_axis_tuser    // is_zero [0]
);

	logic  core_ready;
	logic  core_done;
	logic  take;
	word_t core_res;

	logic              out_valid_q;
	logic [FIELD_BITS-1:0] term_q;
	logic              zero_q;

	assign take = core_done && (!out_valid_q || m_axis_tready);

	blmp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_axis_tvalid && core_ready),
		.n_in   (s_axis_tdata[WORD_BITS-1:0]),
		.m_in   (s_axis_tdata[FIELD_BITS+WORD_BITS-1:FIELD_BITS]),
		.ready  (core_ready),
		.done   (core_done),
		.take   (take),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			term_q <= FIELD_BITS'(core_res);
			zero_q <= (core_res == '0);
		end
	end

	assign s_axis_tready   = core_ready;
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = term_q;
	assign m_axis_tuser[0] = zero_q;

endmodule
